[rtl/wvdpd_pkg.sv]
// ----------------------------------------------------------------------------
// wvdpd_pkg: shared types and constants of the DPCM pixel decoder
// Holds configuration defaults, register indexes and the token type that the
// code classifier hands to the pixel reconstruction part.
// ----------------------------------------------------------------------------
package wvdpd_pkg;

	// Configuration register layout.
	localparam int CFG_W = 11;
	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'd1;
	localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET = 11'd640;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 11'd480;

	// Default frame size limits.
	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	// Depth of the token queue between classifier and reconstruction.
	localparam int QUEUE_DEPTH = 4;

	// How a pixel value is formed from its token.
	typedef enum logic [1:0] {
		PRED_ABS,
		PRED_UP,
		PRED_LEFT,
		PRED_AVG
	} pred_mode_t;

	// One classified code, ready for reconstruction.
	typedef struct packed {
		pred_mode_t       mode;
		logic [7:0]       abs_val;
		logic signed [5:0] delta;
		logic             unk;
		logic             last;
		logic             done;
	} tok_t;

endpackage

[rtl/wvdpd_fifo.sv]
// ----------------------------------------------------------------------------
// wvdpd_fifo: small token queue
// Register based first-in first-out queue that decouples the code classifier
// from the pixel reconstruction stages.
// ----------------------------------------------------------------------------
module wvdpd_fifo #(
	parameter int W = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic         not_empty,
	output logic [W-1:0] pop_data
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [W-1:0]    entry_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CNTW-1:0] count_q;

	assign full = (count_q == CNTW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data = entry_q[rd_ptr_q];

	// Entry storage; payload needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers wrap at the queue depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push || pop)
		else $error("token pushed into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("token popped from an empty queue");

endmodule

[rtl/wvdpd_front.sv]
// ----------------------------------------------------------------------------
// wvdpd_front: bit buffer and code classifier
// Accepts compressed bytes, tracks row and column, and turns each buffered
// code into a token with its line store address, one per cycle unless tok_full.
// ----------------------------------------------------------------------------
module wvdpd_front #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int CW = $clog2(MAX_WIDTH),
	parameter int RW = $clog2(MAX_HEIGHT)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [7:0]                stream_byte,
	input  logic                      start_of_frame,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [wvdpd_pkg::CFG_W-1:0] frame_width,
	input  logic [wvdpd_pkg::CFG_W-1:0] frame_height,
	output logic                      tok_push,
	output wvdpd_pkg::tok_t           tok,
	output logic [CW:0]               tok_addr,
	input  logic                      tok_full
);
	import wvdpd_pkg::*;

	localparam int SW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
	localparam int HW = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;

	logic [14:0]   bb_q;
	logic [3:0]    bc_q;
	logic [2:0]    n_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          active_q;
	logic          busy_q;

	logic [7:0]        code;
	logic              lit;
	logic              col_lt2;
	logic              row_lt2;
	logic [3:0]        len;
	logic              is_abs;
	logic              unk;
	logic signed [5:0] delta;
	logic [3:0]        bc_new;
	logic [14:0]       bb_cons;
	logic [SW-1:0]     w_ext;
	logic [SW-1:0]     w_eff;
	logic [HW-1:0]     h_ext;
	logic [HW-1:0]     h_eff;
	logic              col_last;
	logic              row_last;
	logic              done;
	logic              last;
	logic              emit;
	logic              accept;

	// Prefix code table: length, delta, unknown and absolute flags.
	function automatic logic [11:0] classify(input logic [7:0] c);
		logic [3:0]        f_len;
		logic signed [5:0] f_delta;
		logic              f_abs;
		logic              f_unk;
		f_len = 4'd8;
		f_delta = 6'sd0;
		f_abs = 1'b0;
		f_unk = 1'b0;
		if (!c[7]) begin
			f_len = 4'd1;
		end else if ((c & 8'hE0) == 8'h80) begin
			f_len = 4'd3;
			f_delta = 6'sd4;
		end else if ((c & 8'hE0) == 8'hA0) begin
			f_len = 4'd3;
			f_delta = -6'sd4;
		end else if ((c & 8'hF0) == 8'hD0) begin
			f_len = 4'd4;
			f_delta = 6'sd11;
		end else if ((c & 8'hF0) == 8'hF0) begin
			f_len = 4'd4;
			f_delta = -6'sd11;
		end else if ((c & 8'hF8) == 8'hC8) begin
			f_len = 4'd5;
			f_delta = 6'sd20;
		end else if ((c & 8'hFC) == 8'hC0) begin
			f_len = 4'd6;
			f_delta = -6'sd20;
		end else if ((c & 8'hFC) == 8'hC4) begin
			f_unk = 1'b1;
		end else begin
			f_abs = 1'b1;
		end
		return {f_len, f_delta, f_abs, f_unk};
	endfunction

	// Window of the next eight buffered bits; the count is 8..15 here.
	assign code = 8'(bb_q >> bc_q[2:0]);

	assign col_lt2 = ({1'b0, col_q} < (CW + 1)'(2));
	assign row_lt2 = ({1'b0, row_q} < (RW + 1)'(2));
	assign lit = col_lt2 && row_lt2;

	always_comb begin
		logic [3:0]        c_len;
		logic signed [5:0] c_delta;
		logic              c_abs;
		logic              c_unk;
		{c_len, c_delta, c_abs, c_unk} = classify(code);
		if (lit) begin
			len = 4'd8;
			delta = 6'sd0;
			is_abs = 1'b1;
			unk = 1'b0;
		end else begin
			len = c_len;
			delta = c_delta;
			is_abs = c_abs;
			unk = c_unk;
		end
	end

	// Bits left after this code, with consumed bits masked off.
	assign bc_new = bc_q - len;
	assign bb_cons = bb_q & 15'((16'd1 << bc_new) - 16'd1);

	// Frame size clamped to the supported range.
	assign w_ext = SW'(frame_width);
	assign h_ext = HW'(frame_height);
	assign w_eff = (w_ext < SW'(2)) ? SW'(2) : (w_ext > SW'(MAX_WIDTH)) ? SW'(MAX_WIDTH) : w_ext;
	assign h_eff = (h_ext < HW'(2)) ? HW'(2) :
		(h_ext > HW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : h_ext;
	assign col_last = (SW'(col_q) + SW'(1)) >= w_eff;
	assign row_last = (HW'(row_q) + HW'(1)) >= h_eff;
	assign done = col_last && row_last;

	assign last = (bc_new < 4'd8) || (n_q == 3'd7) || done;
	assign emit = busy_q && !tok_full;
	assign in_stall = busy_q && !(emit && last);
	assign accept = in_valid && !in_stall;

	// Token contents.
	always_comb begin
		tok.abs_val = is_abs ? (lit ? code : {code[3:0], 4'h0}) : 8'h00;
		tok.delta = delta;
		tok.unk = unk;
		tok.last = last;
		tok.done = done;
		if (is_abs) begin
			tok.mode = PRED_ABS;
		end else if (col_lt2) begin
			tok.mode = PRED_UP;
		end else if (row_lt2) begin
			tok.mode = PRED_LEFT;
		end else begin
			tok.mode = PRED_AVG;
		end
	end
	assign tok_addr = {row_q[0], col_q};
	assign tok_push = emit;

	// Buffer, position and frame state.
	always_ff @(posedge clk or negedge arst_n) begin
		logic [14:0]   nb;
		logic [3:0]    nc;
		logic [CW-1:0] ncol;
		logic [RW-1:0] nrow;
		logic          nact;
		if (!arst_n) begin
			bb_q <= '0;
			bc_q <= '0;
			n_q <= '0;
			col_q <= '0;
			row_q <= '0;
			active_q <= 1'b0;
			busy_q <= 1'b0;
		end else begin
			nb = bb_q;
			nc = bc_q;
			ncol = col_q;
			nrow = row_q;
			nact = active_q;
			if (emit) begin
				nb = bb_cons;
				nc = bc_new;
				if (col_last) begin
					ncol = '0;
					if (row_last) begin
						nact = 1'b0;
					end else begin
						nrow = row_q + 1'b1;
					end
				end else begin
					ncol = col_q + 1'b1;
				end
			end
			if (accept && start_of_frame) begin
				nb = '0;
				nc = '0;
				ncol = '0;
				nrow = '0;
				nact = 1'b1;
			end
			if (accept && nact) begin
				bb_q <= {nb[6:0], stream_byte};
				bc_q <= nc + 4'd8;
				n_q <= '0;
				busy_q <= 1'b1;
			end else begin
				bb_q <= nb;
				bc_q <= nc;
				if (emit) begin
					n_q <= n_q + 1'b1;
				end
				if (emit && last) begin
					busy_q <= 1'b0;
				end
			end
			col_q <= ncol;
			row_q <= nrow;
			active_q <= nact;
		end
	end

	a_busy_active: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> active_q)
		else $error("decoding outside an active frame");
	a_busy_has_code: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> bc_q >= 4'd8)
		else $error("fewer than eight bits buffered while decoding");
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy_q && active_q) |-> bc_q < 4'd8)
		else $error("a full code left undecoded in an active frame");

endmodule

[rtl/wvdpd_back.sv]
// ----------------------------------------------------------------------------
// wvdpd_back: pixel reconstruction
// Reads the pixel two rows up from the line store, applies the predictor and
// delta with clamping, writes the result back and holds it for output.
// ----------------------------------------------------------------------------
module wvdpd_back #(
	parameter int AW = 11
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            tok_valid,
	input  wvdpd_pkg::tok_t tok,
	input  logic [AW-1:0]   tok_addr,
	output logic            tok_pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [7:0]      pixel,
	output logic            last_of_run,
	output logic            frame_done,
	output logic [15:0]     unknown_count
);
	import wvdpd_pkg::*;

	logic [7:0]    line_mem [2**AW];

	logic          valid_s1;
	tok_t          tok_s1;
	logic [AW-1:0] addr_s1;
	logic [7:0]    up_s1;

	logic [7:0]  hist1_q;
	logic [7:0]  hist2_q;
	logic [15:0] unk_cnt_q;
	logic        out_valid_q;

	logic              out_free;
	logic              adv1;
	logic [7:0]        pred;
	logic [8:0]        avg_sum;
	logic signed [9:0] sum;
	logic [7:0]        pix;
	logic [15:0]       unk_cnt_next;

	assign out_free = !out_valid_q || !out_stall;
	assign adv1 = valid_s1 && out_free;
	assign tok_pop = tok_valid && (!valid_s1 || adv1);

	// Predictor selection, delta add and clamp to 0..255.
	assign avg_sum = {1'b0, up_s1} + {1'b0, hist2_q};
	always_comb begin
		case (tok_s1.mode)
			PRED_UP:   pred = up_s1;
			PRED_LEFT: pred = hist2_q;
			PRED_AVG:  pred = avg_sum[8:1];
			default:   pred = 8'h00;
		endcase
	end
	assign sum = $signed({2'b00, pred}) + $signed({{4{tok_s1.delta[5]}}, tok_s1.delta});
	always_comb begin
		if (tok_s1.mode == PRED_ABS) begin
			pix = tok_s1.abs_val;
		end else if (sum < 10'sd0) begin
			pix = 8'h00;
		end else if (sum > 10'sd255) begin
			pix = 8'hFF;
		end else begin
			pix = sum[7:0];
		end
	end

	assign unk_cnt_next = (tok_s1.unk && unk_cnt_q != 16'hFFFF) ? unk_cnt_q + 16'd1 : unk_cnt_q;

	// Line store: read when a token enters stage one, write when it retires.
	always_ff @(posedge clk) begin
		if (tok_pop) begin
			up_s1 <= line_mem[tok_addr];
			tok_s1 <= tok;
			addr_s1 <= tok_addr;
		end
		if (adv1) begin
			line_mem[addr_s1] <= pix;
			hist2_q <= hist1_q;
			hist1_q <= pix;
			pixel <= pix;
			last_of_run <= tok_s1.last;
			frame_done <= tok_s1.done;
			unknown_count <= unk_cnt_next;
		end
	end

	// Stage and output valid flags, and the unknown code counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			unk_cnt_q <= '0;
		end else begin
			if (tok_pop) begin
				valid_s1 <= 1'b1;
			end else if (adv1) begin
				valid_s1 <= 1'b0;
			end
			if (adv1) begin
				out_valid_q <= 1'b1;
				unk_cnt_q <= unk_cnt_next;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_read_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv1) |=> $stable(up_s1) && $stable(addr_s1))
		else $error("stage one data changed while waiting");
	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		##1 unk_cnt_q >= $past(unk_cnt_q))
		else $error("unknown code counter went backwards");

endmodule

[rtl/webcam_vlc_dpcm_pixel_decoder.sv]
// ----------------------------------------------------------------------------
// webcam_vlc_dpcm_pixel_decoder: prefix-code DPCM raw Bayer pixel decoder
// Throughput: one pixel per cycle while tokens are queued and out_stall is low.
// Each byte yields 1 to 8 pixels; the front part takes no new byte until the bit
// buffer hands the last code of the current byte to the token queue.
// Reset clears control state and sets the frame size to 640 x 480; the line
// store is not cleared and holds no valid data until written.
// ----------------------------------------------------------------------------
module webcam_vlc_dpcm_pixel_decoder #(
	parameter int MAX_WIDTH = wvdpd_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = wvdpd_pkg::MAX_HEIGHT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [wvdpd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [wvdpd_pkg::CFG_W-1:0]     cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      stream_byte,
	input  logic                            start_of_frame,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [7:0]                      pixel,
	output logic                            last_of_run,
	output logic                            frame_done,
	output logic [15:0]                     unknown_count
);
	import wvdpd_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int AW = CW + 1;
	localparam int QW = $bits(tok_t) + AW;

	logic [CFG_W-1:0] frame_width_q;
	logic [CFG_W-1:0] frame_height_q;

	logic          f_push;
	tok_t          f_tok;
	logic [AW-1:0] f_addr;
	logic          q_full;
	logic          q_pop;
	logic          q_valid;
	logic [QW-1:0] q_data;
	tok_t          b_tok;
	logic [AW-1:0] b_addr;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= FRAME_WIDTH_RESET;
			frame_height_q <= FRAME_HEIGHT_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default:          ;
			endcase
		end
	end

	wvdpd_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.CW        (CW),
		.RW        (RW)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.stream_byte   (stream_byte),
		.start_of_frame(start_of_frame),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.frame_width   (frame_width_q),
		.frame_height  (frame_height_q),
		.tok_push      (f_push),
		.tok           (f_tok),
		.tok_addr      (f_addr),
		.tok_full      (q_full)
	);

	wvdpd_fifo #(
		.W    (QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (f_push),
		.push_data({f_tok, f_addr}),
		.full     (q_full),
		.pop      (q_pop),
		.not_empty(q_valid),
		.pop_data (q_data)
	);

	assign {b_tok, b_addr} = q_data;

	wvdpd_back #(
		.AW(AW)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.tok_valid    (q_valid),
		.tok          (b_tok),
		.tok_addr     (b_addr),
		.tok_pop      (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel        (pixel),
		.last_of_run  (last_of_run),
		.frame_done   (frame_done),
		.unknown_count(unknown_count)
	);

endmodule
